// ===== src/gtg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gtg_pkg;

  // datapath widths
  localparam int unsigned XY_W      = 32;
  localparam int unsigned Z_W       = 28;
  localparam int unsigned ISQ_BITS  = 17;
  localparam int unsigned ISQ_IN_W  = 34;
  localparam int unsigned NUM_W     = 61;
  localparam int unsigned REM_W     = 52;
  localparam int unsigned DEN_W     = 29;
  localparam int unsigned Q_BITS    = 15;

  // angles in 1/8192 rad, wide enough for the raw heading error
  localparam logic signed [17:0] E_PI      = 18'sd25736;
  localparam logic signed [17:0] E_HALF_PI = 18'sd12868;
  localparam logic signed [17:0] E_TWO_PI  = 18'sd51472;

  // CORDIC constants, angles in 2^-24 rad
  localparam logic signed [Z_W-1:0] Z_HALF_PI = 28'sd26353589;
  localparam logic signed [XY_W-1:0] ROT_X0   = 32'sd268435456;

  // register indexes
  localparam logic [2:0] REG_TARGET_X   = 3'd0;
  localparam logic [2:0] REG_TARGET_Y   = 3'd1;
  localparam logic [2:0] REG_SPEED_GAIN = 3'd2;
  localparam logic [2:0] REG_HEAD_GAIN  = 3'd3;
  localparam logic [2:0] REG_MAX_SPEED  = 3'd4;
  localparam logic [2:0] REG_MAX_STEER  = 3'd5;
  localparam logic [2:0] REG_INV_OFFSET = 3'd6;

  function automatic logic [24:0] atan_fine(input int unsigned i);
    logic [24:0] a;
    case (i)
      0:  a = 25'd13176795;
      1:  a = 25'd7778716;
      2:  a = 25'd4110060;
      3:  a = 25'd2086331;
      4:  a = 25'd1047214;
      5:  a = 25'd524117;
      6:  a = 25'd262123;
      7:  a = 25'd131069;
      8:  a = 25'd65536;
      9:  a = 25'd32768;
      10: a = 25'd16384;
      11: a = 25'd8192;
      12: a = 25'd4096;
      13: a = 25'd2048;
      14: a = 25'd1024;
      15: a = 25'd512;
      16: a = 25'd256;
      17: a = 25'd128;
      18: a = 25'd64;
      19: a = 25'd32;
      20: a = 25'd16;
      21: a = 25'd8;
      22: a = 25'd4;
      23: a = 25'd2;
      default: a = 25'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== src/gtg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gtg_front #(
  parameter int unsigned STEPS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic signed [16:0]     ex,
  input  logic signed [16:0]     ey,
  input  logic signed [15:0]     hd_in,
  output logic                   out_vld,
  output logic signed [16:0]     bearing,
  output logic [gtg_pkg::ISQ_BITS-1:0] dist_out,
  output logic signed [15:0]     hd_out
);
  import gtg_pkg::*;

  localparam int unsigned DEPTH = (STEPS > ISQ_BITS) ? STEPS : ISQ_BITS;

  logic                   vld_r   [0:DEPTH];
  logic signed [XY_W-1:0] x_r     [0:DEPTH];
  logic signed [XY_W-1:0] y_r     [0:DEPTH];
  logic signed [Z_W-1:0]  z_r     [0:DEPTH];
  logic                   zero_r  [0:DEPTH];
  logic signed [15:0]     hd_r    [0:DEPTH];
  logic [ISQ_IN_W-1:0]    sn_r    [0:DEPTH];
  logic [ISQ_BITS:0]      srem_r  [0:DEPTH];
  logic [ISQ_BITS-1:0]    sroot_r [0:DEPTH];

  logic signed [33:0]     ex2, ey2;
  logic [ISQ_IN_W-1:0]    sq_nxt;
  logic signed [XY_W-1:0] exw, eyw, px, py;
  logic signed [Z_W-1:0]  pz;
  logic signed [Z_W-1:0]  zr;

  assign ex2    = ex * ex;
  assign ey2    = ey * ey;
  assign sq_nxt = ISQ_IN_W'(ex2) + ISQ_IN_W'(ey2);
  assign exw    = XY_W'(ex);
  assign eyw    = XY_W'(ey);

  // pre-rotate into the right half plane
  always_comb begin
    if (ex < 0) begin
      if (ey >= 0) begin
        px = eyw;
        py = -exw;
        pz = Z_HALF_PI;
      end else begin
        px = -eyw;
        py = exw;
        pz = -Z_HALF_PI;
      end
    end else begin
      px = exw;
      py = eyw;
      pz = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]     <= px <<< 12;
      y_r[0]     <= py <<< 12;
      z_r[0]     <= pz;
      zero_r[0]  <= (ex == 0) && (ey == 0);
      hd_r[0]    <= hd_in;
      sn_r[0]    <= sq_nxt;
      srem_r[0]  <= '0;
      sroot_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= DEPTH; k++) begin : g_st
    localparam int unsigned I = k - 1;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[k] <= zero_r[k-1];
        hd_r[k]   <= hd_r[k-1];
      end
    end

    if (I < STEPS) begin : g_cor
      logic signed [XY_W-1:0] dx, dy;
      logic signed [Z_W-1:0]  at;
      assign dx = y_r[k-1] >>> I;
      assign dy = x_r[k-1] >>> I;
      assign at = Z_W'(atan_fine(I));
      // drive y towards zero, accumulate the angle
      always_ff @(posedge clk) begin
        if (en) begin
          if (y_r[k-1] > 0) begin
            x_r[k] <= x_r[k-1] + dx;
            y_r[k] <= y_r[k-1] - dy;
            z_r[k] <= z_r[k-1] + at;
          end else begin
            x_r[k] <= x_r[k-1] - dx;
            y_r[k] <= y_r[k-1] + dy;
            z_r[k] <= z_r[k-1] - at;
          end
        end
      end
    end else begin : g_cpass
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[k] <= x_r[k-1];
          y_r[k] <= y_r[k-1];
          z_r[k] <= z_r[k-1];
        end
      end
    end

    if (I < ISQ_BITS) begin : g_sq
      logic [ISQ_BITS+2:0] rt, tr;
      logic                ge;
      assign rt = {srem_r[k-1], sn_r[k-1][ISQ_IN_W-1 -: 2]};
      assign tr = {1'b0, sroot_r[k-1], 2'b01};
      assign ge = rt >= tr;
      // one root bit per stage
      always_ff @(posedge clk) begin
        if (en) begin
          srem_r[k]  <= ge ? (ISQ_BITS+1)'(rt - tr) : rt[ISQ_BITS:0];
          sroot_r[k] <= {sroot_r[k-1][ISQ_BITS-2:0], ge};
          sn_r[k]    <= {sn_r[k-1][ISQ_IN_W-3:0], 2'b00};
        end
      end
    end else begin : g_spass
      always_ff @(posedge clk) begin
        if (en) begin
          srem_r[k]  <= srem_r[k-1];
          sroot_r[k] <= sroot_r[k-1];
          sn_r[k]    <= sn_r[k-1];
        end
      end
    end
  end

  assign zr       = z_r[DEPTH] + Z_W'(1024);
  assign bearing  = zero_r[DEPTH] ? 17'sd0 : signed'(zr[Z_W-1:11]);
  assign dist_out = sroot_r[DEPTH];
  assign hd_out   = hd_r[DEPTH];
  assign out_vld  = vld_r[DEPTH];

endmodule
`default_nettype wire

// ===== src/gtg_rot.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gtg_rot #(
  parameter int unsigned STEPS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic signed [gtg_pkg::Z_W-1:0] z_in,
  input  logic [14:0]                    vmag_in,
  input  logic                           vneg_in,
  output logic                           out_vld,
  output logic signed [gtg_pkg::XY_W-1:0] x_out,
  output logic signed [gtg_pkg::XY_W-1:0] y_out,
  output logic [14:0]                    vmag_out,
  output logic                           vneg_out
);
  import gtg_pkg::*;

  logic                   vld_r  [0:STEPS];
  logic signed [XY_W-1:0] x_r    [0:STEPS];
  logic signed [XY_W-1:0] y_r    [0:STEPS];
  logic signed [Z_W-1:0]  z_r    [0:STEPS];
  logic [14:0]            vmag_r [0:STEPS];
  logic                   vneg_r [0:STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= ROT_X0;
      y_r[0]    <= '0;
      z_r[0]    <= z_in;
      vmag_r[0] <= vmag_in;
      vneg_r[0] <= vneg_in;
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_st
    localparam int unsigned I = k - 1;
    logic signed [XY_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  at;
    assign dx = y_r[k-1] >>> I;
    assign dy = x_r[k-1] >>> I;
    assign at = Z_W'(atan_fine(I));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    // drive the residual angle towards zero
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[k-1] >= 0) begin
          x_r[k] <= x_r[k-1] - dx;
          y_r[k] <= y_r[k-1] + dy;
          z_r[k] <= z_r[k-1] - at;
        end else begin
          x_r[k] <= x_r[k-1] + dx;
          y_r[k] <= y_r[k-1] - dy;
          z_r[k] <= z_r[k-1] + at;
        end
        vmag_r[k] <= vmag_r[k-1];
        vneg_r[k] <= vneg_r[k-1];
      end
    end
  end

  assign out_vld  = vld_r[STEPS];
  assign x_out    = x_r[STEPS];
  assign y_out    = y_r[STEPS];
  assign vmag_out = vmag_r[STEPS];
  assign vneg_out = vneg_r[STEPS];

endmodule
`default_nettype wire

// ===== src/gtg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gtg_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic [gtg_pkg::NUM_W-1:0]        nn,
  input  logic [gtg_pkg::DEN_W-1:0]        den,
  input  logic                             xpos,
  input  logic                             wneg_in,
  input  logic [14:0]                      vmag_in,
  input  logic                             vneg_in,
  output logic                             out_vld,
  output logic [gtg_pkg::Q_BITS-1:0]       wmag,
  output logic                             wneg_out,
  output logic [14:0]                      vmag_out,
  output logic                             vneg_out
);
  import gtg_pkg::*;

  logic              vld_r  [0:Q_BITS];
  logic [REM_W-1:0]  rem_r  [0:Q_BITS];
  logic [DEN_W-1:0]  den_r  [0:Q_BITS];
  logic [Q_BITS-1:0] q_r    [0:Q_BITS];
  logic              sat_r  [0:Q_BITS];
  logic              xpos_r [0:Q_BITS];
  logic              wneg_r [0:Q_BITS];
  logic [14:0]       vmag_r [0:Q_BITS];
  logic              vneg_r [0:Q_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  // quotient of 2^15 or more saturates
  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0]  <= nn >= (NUM_W'(den) << (8 + Q_BITS));
      rem_r[0]  <= nn[REM_W-1:0];
      den_r[0]  <= den;
      q_r[0]    <= '0;
      xpos_r[0] <= xpos;
      wneg_r[0] <= wneg_in;
      vmag_r[0] <= vmag_in;
      vneg_r[0] <= vneg_in;
    end
  end

  for (genvar k = 1; k <= Q_BITS; k++) begin : g_st
    localparam int unsigned B = Q_BITS - k;
    logic [REM_W-1:0] dsh;
    logic             ge;
    assign dsh = REM_W'(den_r[k-1]) << (8 + B);
    assign ge  = rem_r[k-1] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? rem_r[k-1] - dsh : rem_r[k-1];
        q_r[k]    <= {q_r[k-1][Q_BITS-2:0], ge};
        den_r[k]  <= den_r[k-1];
        sat_r[k]  <= sat_r[k-1];
        xpos_r[k] <= xpos_r[k-1];
        wneg_r[k] <= wneg_r[k-1];
        vmag_r[k] <= vmag_r[k-1];
        vneg_r[k] <= vneg_r[k-1];
      end
    end
  end

  assign out_vld  = vld_r[Q_BITS];
  assign wmag     = !xpos_r[Q_BITS] ? '0 : (sat_r[Q_BITS] ? '1 : q_r[Q_BITS]);
  assign wneg_out = wneg_r[Q_BITS];
  assign vmag_out = vmag_r[Q_BITS];
  assign vneg_out = vneg_r[Q_BITS];

endmodule
`default_nettype wire

// ===== src/go_to_goal_kinematic_controller_unit.sv =====
// Go-to-goal steering for a differential drive robot.
// Input stream: one pose word per beat (pos_x, pos_y, heading). Output
// stream: one command word per pose (lin_speed, ang_speed), in order.
// Configuration: APB port with seven registers at byte offsets 0x00..0x18
// (target x/y, speed gain, heading gain, speed limit, steer limit,
// inverse offset); write them only while the stream is quiet.
// Throughput: one pose per cycle while the output is not stalled. The path
// from an accepted pose to its command on out_tvalid runs through the
// bearing CORDIC beside the bit-per-stage square root, the steering CORDIC
// and the 16-stage divider.
// Reset (rst_n low, synchronous) empties the pipeline, dropping any poses
// in flight, and loads the register defaults; no command is issued during it.
// Stall: while out_tvalid is high and out_tready low the whole pipeline
// holds, in_tready drops and nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module go_to_goal_kinematic_controller_unit #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // pose in: [15:0] pos_x, [31:16] pos_y, [47:32] heading
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // command out: [15:0] lin_speed, [31:16] ang_speed
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import gtg_pkg::*;

  // ---------------------------------------------------------------- registers
  logic [15:0] tx_r, ty_r, sg_r, hg_r, io_r;
  logic [14:0] ms_r;
  logic [12:0] mst_r;
  logic        wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r  <= 16'd2048;
      ty_r  <= 16'd1638;
      sg_r  <= 16'd256;
      hg_r  <= 16'd256;
      ms_r  <= 15'd819;
      mst_r <= 13'd6434;
      io_r  <= 16'd256;
    end else if (wr) begin
      case (cfg_paddr[4:2])
        REG_TARGET_X:   tx_r  <= cfg_pwdata[15:0];
        REG_TARGET_Y:   ty_r  <= cfg_pwdata[15:0];
        REG_SPEED_GAIN: sg_r  <= cfg_pwdata[15:0];
        REG_HEAD_GAIN:  hg_r  <= cfg_pwdata[15:0];
        REG_MAX_SPEED:  ms_r  <= cfg_pwdata[14:0];
        REG_MAX_STEER:  mst_r <= cfg_pwdata[12:0];
        REG_INV_OFFSET: io_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_TARGET_X:   cfg_prdata = 32'(tx_r);
      REG_TARGET_Y:   cfg_prdata = 32'(ty_r);
      REG_SPEED_GAIN: cfg_prdata = 32'(sg_r);
      REG_HEAD_GAIN:  cfg_prdata = 32'(hg_r);
      REG_MAX_SPEED:  cfg_prdata = 32'(ms_r);
      REG_MAX_STEER:  cfg_prdata = 32'(mst_r);
      REG_INV_OFFSET: cfg_prdata = 32'(io_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ flow control
  // One shared advance: every stage moves when the output slot is free.
  logic out_vld_r;
  logic adv;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  // --------------------------------------------------------- position error
  logic               s0_vld_r;
  logic signed [16:0] s0_ex_r, s0_ey_r;
  logic signed [15:0] s0_hd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ex_r <= 17'(signed'(tx_r)) - 17'(signed'(in_tdata[15:0]));
      s0_ey_r <= 17'(signed'(ty_r)) - 17'(signed'(in_tdata[31:16]));
      s0_hd_r <= signed'(in_tdata[47:32]);
    end
  end

  // ------------------------------------------- bearing and distance to goal
  logic                f_vld;
  logic signed [16:0]  f_bear;
  logic [ISQ_BITS-1:0] f_dist;
  logic signed [15:0]  f_hd;

  gtg_front #(.STEPS(CORDIC_STEPS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (s0_vld_r),
    .ex       (s0_ex_r),
    .ey       (s0_ey_r),
    .hd_in    (s0_hd_r),
    .out_vld  (f_vld),
    .bearing  (f_bear),
    .dist_out (f_dist),
    .hd_out   (f_hd)
  );

  // ------------------------------------- heading error wrap and fold, speed
  logic signed [17:0] e_diff, e_wr, e_fd;
  logic               bh_nxt;

  assign e_diff = 18'(f_bear) - 18'(f_hd);

  always_comb begin
    if (e_diff > E_PI) begin
      e_wr = e_diff - E_TWO_PI;
    end else if (e_diff <= -E_PI) begin
      e_wr = e_diff + E_TWO_PI;
    end else begin
      e_wr = e_diff;
    end
    // exactly +-pi/2 counts as ahead
    if (e_wr > E_HALF_PI) begin
      e_fd   = e_wr - E_PI;
      bh_nxt = 1'b1;
    end else if (e_wr < -E_HALF_PI) begin
      e_fd   = e_wr + E_PI;
      bh_nxt = 1'b1;
    end else begin
      e_fd   = e_wr;
      bh_nxt = 1'b0;
    end
  end

  logic               b1_vld_r, b1_bh_r;
  logic signed [14:0] b1_e_r;
  logic [32:0]        b1_vp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r <= 1'b0;
    end else if (adv) begin
      b1_vld_r <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_e_r  <= e_fd[14:0];
      b1_bh_r <= bh_nxt;
      b1_vp_r <= f_dist * sg_r;
    end
  end

  // ------------------------------------- speed saturation, steering product
  logic [33:0] vr_sum;
  logic [25:0] vr;
  logic [14:0] vmag_nxt;
  logic [14:0] ae;

  assign vr_sum   = 34'(b1_vp_r) + 34'd128;
  assign vr       = vr_sum[33:8];
  assign vmag_nxt = (vr > 26'(ms_r)) ? ms_r : vr[14:0];
  assign ae       = (b1_e_r < 0) ? 15'(-b1_e_r) : 15'(b1_e_r);

  logic        b2_vld_r, b2_bh_r, b2_an_r;
  logic [14:0] b2_vmag_r;
  logic [29:0] b2_ap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_vld_r <= 1'b0;
    end else if (adv) begin
      b2_vld_r <= b1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_vmag_r <= vmag_nxt;
      b2_bh_r   <= b1_bh_r;
      b2_an_r   <= b1_e_r < 0;
      b2_ap_r   <= ae[13:0] * hg_r;
    end
  end

  // ------------------------------------------------ steering angle clamp
  logic [30:0]           ar_sum;
  logic [22:0]           ar;
  logic [12:0]           amag;
  logic signed [Z_W-1:0] zpos;

  assign ar_sum = 31'(b2_ap_r) + 31'd128;
  assign ar     = ar_sum[30:8];
  assign amag   = (ar > 23'(mst_r)) ? mst_r : ar[12:0];
  assign zpos   = signed'(Z_W'({amag, 11'b0}));

  logic                  b3_vld_r, b3_vneg_r;
  logic signed [Z_W-1:0] b3_z_r;
  logic [14:0]           b3_vmag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b3_vld_r <= 1'b0;
    end else if (adv) begin
      b3_vld_r <= b2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b3_z_r    <= b2_an_r ? -zpos : zpos;
      b3_vmag_r <= b2_vmag_r;
      b3_vneg_r <= b2_bh_r && (b2_vmag_r != '0);
    end
  end

  // ----------------------------------------- tan of steering: sin and cos
  logic                   r_vld, r_vneg;
  logic signed [XY_W-1:0] r_x, r_y;
  logic [14:0]            r_vmag;

  gtg_rot #(.STEPS(CORDIC_STEPS)) u_rot (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (b3_vld_r),
    .z_in     (b3_z_r),
    .vmag_in  (b3_vmag_r),
    .vneg_in  (b3_vneg_r),
    .out_vld  (r_vld),
    .x_out    (r_x),
    .y_out    (r_y),
    .vmag_out (r_vmag),
    .vneg_out (r_vneg)
  );

  // ------------------------------------ numerator v * |sin| * inverse offset
  logic [XY_W-1:0] yabs;

  assign yabs = (r_y < 0) ? XY_W'(-r_y) : XY_W'(r_y);

  logic             p1_vld_r, p1_wneg_r, p1_xpos_r, p1_vneg_r;
  logic [44:0]      p1_yi_r;
  logic [DEN_W-1:0] p1_xm_r;
  logic [14:0]      p1_vmag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= r_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_yi_r   <= yabs[DEN_W-1:0] * io_r;
      p1_xm_r   <= r_x[DEN_W-1:0];
      p1_xpos_r <= r_x > 0;
      p1_wneg_r <= r_vneg != (r_y < 0);
      p1_vmag_r <= r_vmag;
      p1_vneg_r <= r_vneg;
    end
  end

  // split the wide product into two partial products
  logic             p2_vld_r, p2_wneg_r, p2_xpos_r, p2_vneg_r;
  logic [37:0]      p2_lo_r;
  logic [36:0]      p2_hi_r;
  logic [DEN_W-1:0] p2_xm_r;
  logic [14:0]      p2_vmag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (adv) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_lo_r   <= p1_yi_r[22:0] * p1_vmag_r;
      p2_hi_r   <= p1_yi_r[44:23] * p1_vmag_r;
      p2_xm_r   <= p1_xm_r;
      p2_xpos_r <= p1_xpos_r;
      p2_wneg_r <= p1_wneg_r;
      p2_vmag_r <= p1_vmag_r;
      p2_vneg_r <= p1_vneg_r;
    end
  end

  // sum partials and add half the denominator for rounding
  logic             p3_vld_r, p3_wneg_r, p3_xpos_r, p3_vneg_r;
  logic [NUM_W-1:0] p3_nn_r;
  logic [DEN_W-1:0] p3_xm_r;
  logic [14:0]      p3_vmag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (adv) begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_nn_r   <= (NUM_W'(p2_hi_r) << 23) + NUM_W'(p2_lo_r) + (NUM_W'(p2_xm_r) << 7);
      p3_xm_r   <= p2_xm_r;
      p3_xpos_r <= p2_xpos_r;
      p3_wneg_r <= p2_wneg_r;
      p3_vmag_r <= p2_vmag_r;
      p3_vneg_r <= p2_vneg_r;
    end
  end

  // ---------------------------------------------- divide by 256 * cos
  logic              d_vld, d_wneg, d_vneg;
  logic [Q_BITS-1:0] d_wmag;
  logic [14:0]       d_vmag;

  gtg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (p3_vld_r),
    .nn       (p3_nn_r),
    .den      (p3_xm_r),
    .xpos     (p3_xpos_r),
    .wneg_in  (p3_wneg_r),
    .vmag_in  (p3_vmag_r),
    .vneg_in  (p3_vneg_r),
    .out_vld  (d_vld),
    .wmag     (d_wmag),
    .wneg_out (d_wneg),
    .vmag_out (d_vmag),
    .vneg_out (d_vneg)
  );

  // ------------------------------------------------------- output register
  logic [15:0] lin_r, ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lin_r <= d_vneg ? -16'(d_vmag) : 16'(d_vmag);
      ang_r <= d_wneg ? -16'(d_wmag) : 16'(d_wmag);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {ang_r, lin_r};

`ifndef SYNTHESIS
  // zero speed always yields zero turn rate
  a_zero_turn: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[15:0] == 16'd0) |-> out_tdata[31:16] == 16'd0)
    else $error("turn rate without linear speed");

  // a held result must back-pressure the input
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  // nothing emerges straight out of reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire
